// File: design/smsd_pkg.sv
package smsd_pkg;

  // Sample format and store depth
  localparam int SAMPLE_BITS = 24;
  localparam int MAX_SAMPLES = 1024;

  // Derived widths
  localparam int ADDR_W     = $clog2(MAX_SAMPLES);
  localparam int CNT_W      = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W      = SAMPLE_BITS + ADDR_W;
  localparam int SQ_W       = 2 * SAMPLE_BITS;
  localparam int ACC_W      = SQ_W + ADDR_W;
  localparam int DIV_W      = ACC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int ROOT_REM_W = SAMPLE_BITS + 2;
  localparam int ROOT_CNT_W = $clog2(SAMPLE_BITS);

  // Input item
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] mean_value;
    logic [SAMPLE_BITS-1:0] std_deviation;
    logic [CNT_W-1:0]       sample_count;
    logic                   overflowed;
  } out_item_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Square root request and response
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                   done;
    logic [SAMPLE_BITS-1:0] root;
  } sqrt_rsp_t;

endpackage

// File: design/smsd_ram.sv
module smsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/smsd_div.sv
module smsd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  smsd_pkg::div_req_t req,
  output smsd_pkg::div_rsp_t rsp
);

  logic                           busy_r;
  logic                           done_r;
  logic [smsd_pkg::DIV_W-1:0]     quo_r;
  logic [smsd_pkg::CNT_W-1:0]     rem_r;
  logic [smsd_pkg::CNT_W-1:0]     divisor_r;
  logic [smsd_pkg::DIV_CNT_W-1:0] step_r;

  logic [smsd_pkg::CNT_W:0]   trial;
  logic [smsd_pkg::CNT_W:0]   diff;
  logic                       ge;
  logic [smsd_pkg::CNT_W-1:0] rem_nxt;

  // Bring down one dividend bit and try a subtract
  always_comb begin
    trial   = {rem_r, quo_r[smsd_pkg::DIV_W-1]};
    diff    = trial - {1'b0, divisor_r};
    ge      = (trial >= {1'b0, divisor_r});
    rem_nxt = ge ? diff[smsd_pkg::CNT_W-1:0] : trial[smsd_pkg::CNT_W-1:0];
  end

  // Iterate one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r    <= 1'b1;
        quo_r     <= req.dividend;
        rem_r     <= '0;
        divisor_r <= req.divisor;
        step_r    <= '0;
      end else if (busy_r) begin
        quo_r  <= {quo_r[smsd_pkg::DIV_W-2:0], ge};
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == smsd_pkg::DIV_CNT_W'(smsd_pkg::DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: design/smsd_sqrt.sv
module smsd_sqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  smsd_pkg::sqrt_req_t req,
  output smsd_pkg::sqrt_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [smsd_pkg::SQ_W-1:0]       rad_r;
  logic [smsd_pkg::SAMPLE_BITS-1:0] root_r;
  logic [smsd_pkg::ROOT_REM_W-1:0] rem_r;
  logic [smsd_pkg::ROOT_CNT_W-1:0] step_r;

  logic [smsd_pkg::ROOT_REM_W+1:0] shifted;
  logic [smsd_pkg::ROOT_REM_W+1:0] trial;
  logic [smsd_pkg::ROOT_REM_W+1:0] diff;
  logic                            ge;

  // Bring down two radicand bits and try root*4+1
  always_comb begin
    shifted = {rem_r, rad_r[smsd_pkg::SQ_W-1 -: 2]};
    trial   = {2'b00, root_r, 2'b01};
    diff    = shifted - trial;
    ge      = (shifted >= trial);
  end

  // Iterate one root bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        rad_r  <= req.radicand;
        root_r <= '0;
        rem_r  <= '0;
        step_r <= '0;
      end else if (busy_r) begin
        rad_r  <= {rad_r[smsd_pkg::SQ_W-3:0], 2'b00};
        root_r <= {root_r[smsd_pkg::SAMPLE_BITS-2:0], ge};
        rem_r  <= ge ? diff[smsd_pkg::ROOT_REM_W-1:0] : shifted[smsd_pkg::ROOT_REM_W-1:0];
        step_r <= step_r + 1'b1;
        if (step_r == smsd_pkg::ROOT_CNT_W'(smsd_pkg::SAMPLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// File: design/sample_mean_and_std_dev_top.sv
// Samples are taken one per cycle while start is high and busy is low; each item is written
// to the sample RAM while it has room, else it is dropped and flagged as overflowed.
// After the item marked last, busy stays high through a serial divide for the mean, a RAM
// read pass, a second divide and a square root. The result strobes on out_valid for one
// cycle as busy falls; the receiver cannot stall. Synchronous active-low reset clears count,
// sum and flags; RAM is not cleared.
module sample_mean_and_std_dev_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smsd_pkg::in_item_t  in_item,
  output logic                out_valid,
  output smsd_pkg::out_item_t out_item
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_PASS,
    S_VAR_GO,
    S_VAR_WAIT,
    S_SQRT_GO,
    S_SQRT_WAIT
  } state_t;

  state_t state_r;

  logic [smsd_pkg::CNT_W-1:0]       count_r;
  logic [smsd_pkg::SUM_W-1:0]       sum_r;
  logic                             drop_r;
  logic [smsd_pkg::SAMPLE_BITS-1:0] mean_r;
  logic [smsd_pkg::SQ_W-1:0]        var_r;
  logic [smsd_pkg::CNT_W-1:0]       rd_idx_r;
  logic                             v1_r;
  logic                             v2_r;
  logic                             v3_r;
  logic [smsd_pkg::SAMPLE_BITS-1:0] diff_r;
  logic [smsd_pkg::SQ_W-1:0]        sq_r;
  logic [smsd_pkg::ACC_W-1:0]       acc_r;
  logic                             out_valid_r;
  smsd_pkg::out_item_t              out_item_r;

  logic                             accept;
  logic                             has_room;
  logic                             issue;
  logic [smsd_pkg::SAMPLE_BITS-1:0] rdata;
  logic [smsd_pkg::SAMPLE_BITS-1:0] abs_diff;
  logic [smsd_pkg::SQ_W-1:0]        sq_w;

  smsd_pkg::div_req_t  div_req;
  smsd_pkg::div_rsp_t  div_rsp;
  smsd_pkg::sqrt_req_t sqrt_req;
  smsd_pkg::sqrt_rsp_t sqrt_rsp;

  // Accept an item only while loading
  assign busy     = (state_r != S_LOAD);
  assign accept   = start && !busy;
  assign has_room = (count_r != smsd_pkg::CNT_W'(smsd_pkg::MAX_SAMPLES));
  assign issue    = (state_r == S_PASS) && (rd_idx_r != count_r);

  smsd_ram #(
    .WIDTH (smsd_pkg::SAMPLE_BITS),
    .DEPTH (smsd_pkg::MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (accept && has_room),
    .waddr (count_r[smsd_pkg::ADDR_W-1:0]),
    .wdata (in_item.sample),
    .raddr (rd_idx_r[smsd_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Share one divider between mean and variance
  always_comb begin
    div_req.start    = (state_r == S_MEAN_GO) || (state_r == S_VAR_GO);
    div_req.dividend = (state_r == S_MEAN_GO) ? smsd_pkg::DIV_W'(sum_r) : acc_r;
    div_req.divisor  = count_r;
  end

  smsd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    sqrt_req.start    = (state_r == S_SQRT_GO);
    sqrt_req.radicand = var_r;
  end

  smsd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // Deviation and its square for the pass pipeline
  assign abs_diff = (rdata >= mean_r) ? (rdata - mean_r) : (mean_r - rdata);
  assign sq_w     = diff_r * diff_r;

  // Sequence load, mean, pass, variance, root and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      sum_r       <= '0;
      drop_r      <= 1'b0;
      rd_idx_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      // Move the pass pipeline along
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (v1_r) begin
        diff_r <= abs_diff;
      end
      if (v2_r) begin
        sq_r <= sq_w;
      end
      if (v3_r) begin
        acc_r <= acc_r + smsd_pkg::ACC_W'(sq_r);
      end
      if (issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end

      unique case (state_r)
        S_LOAD: begin
          if (accept) begin
            if (has_room) begin
              count_r <= count_r + 1'b1;
              sum_r   <= sum_r + smsd_pkg::SUM_W'(in_item.sample);
            end else begin
              drop_r <= 1'b1;
            end
            if (in_item.last) begin
              state_r <= S_MEAN_GO;
            end
          end
        end
        S_MEAN_GO: begin
          rd_idx_r <= '0;
          acc_r    <= '0;
          state_r  <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean_r  <= div_rsp.quotient[smsd_pkg::SAMPLE_BITS-1:0];
            state_r <= S_PASS;
          end
        end
        S_PASS: begin
          // Leave once every read has drained into the sum
          if (!issue && !v1_r && !v2_r && !v3_r) begin
            state_r <= S_VAR_GO;
          end
        end
        S_VAR_GO: begin
          state_r <= S_VAR_WAIT;
        end
        S_VAR_WAIT: begin
          if (div_rsp.done) begin
            var_r   <= div_rsp.quotient[smsd_pkg::SQ_W-1:0];
            state_r <= S_SQRT_GO;
          end
        end
        S_SQRT_GO: begin
          state_r <= S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (sqrt_rsp.done) begin
            out_valid_r              <= 1'b1;
            out_item_r.mean_value    <= mean_r;
            out_item_r.std_deviation <= sqrt_rsp.root;
            out_item_r.sample_count  <= count_r;
            out_item_r.overflowed    <= drop_r;
            count_r                  <= '0;
            sum_r                    <= '0;
            drop_r                   <= 1'b0;
            state_r                  <= S_LOAD;
          end
        end
        default: begin
          state_r <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
